// File: rtl/core/lfu_pkg.sv
// Shared types and constants for the least-frequently-used cache.
// Used by lfu_ctrl, lfu_dp and lfu_cache_replacement_top; no dependencies.
package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int DATA_BITS  = 32;
  localparam int COUNT_BITS = 16;

  localparam int KEY_BITS   = 32;
  localparam int WORD_BITS  = 32;
  localparam int SLOT_BITS  = 4;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int TREE_N     = 1 << IDX_BITS;
  localparam int FILL_BITS  = $clog2(ENTRIES + 1);
  localparam int LVL_BITS   = $clog2(IDX_BITS + 1);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [KEY_BITS-1:0]  key;
    logic [WORD_BITS-1:0] data_in;
  } lfu_in_t;

  typedef struct packed {
    logic                 hit;
    logic [WORD_BITS-1:0] data_out;
    logic [SLOT_BITS-1:0] slot;
    logic                 evicted;
  } lfu_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_REDUCE,
    ST_UPDATE
  } lfu_state_t;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic reduce;
    logic update;
  } lfu_cmd_t;

  typedef struct packed {
    logic evict_need;
  } lfu_stat_t;

endpackage

// File: rtl/core/lfu_ctrl.sv
// Sequencer for the LFU cache: request capture, lookup, min-count tree, update.
// Depends on lfu_pkg.
module lfu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lfu_pkg::lfu_stat_t stat,
  output lfu_pkg::lfu_cmd_t  cmd
);
  import lfu_pkg::*;

  lfu_state_t          state_r, state_nxt;
  logic [LVL_BITS-1:0] lvl_r, lvl_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lvl_r   <= '0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lvl_nxt   = lvl_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        lvl_nxt    = '0;
        state_nxt  = stat.evict_need ? ST_REDUCE : ST_UPDATE;
      end
      ST_REDUCE: begin
        // one tree level per cycle
        cmd.reduce = 1'b1;
        if (lvl_r == LVL_BITS'(IDX_BITS - 1)) begin
          state_nxt = ST_UPDATE;
        end else begin
          lvl_nxt = lvl_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/lfu_dp.sv
// Datapath of the LFU cache: slot storage, key compare, min-count tree, write-back.
// Depends on lfu_pkg; driven by lfu_ctrl through lfu_cmd_t.
module lfu_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  lfu_pkg::lfu_cmd_t  cmd,
  output lfu_pkg::lfu_stat_t stat,
  input  lfu_pkg::lfu_in_t   in_word,
  output logic               out_strobe,
  output lfu_pkg::lfu_out_t  out_word
);
  import lfu_pkg::*;

  typedef struct packed {
    logic                  ok;
    logic [COUNT_BITS-1:0] uses;
    logic [IDX_BITS-1:0]   idx;
  } lfu_cand_t;

  function automatic lfu_cand_t pick(lfu_cand_t a, lfu_cand_t b);
    lfu_cand_t res;
    // ties keep the left (lower index) side
    if (!b.ok) begin
      res = a;
    end else if (!a.ok) begin
      res = b;
    end else if (b.uses < a.uses) begin
      res = b;
    end else begin
      res = a;
    end
    return res;
  endfunction

  lfu_in_t               req_r;
  logic                  hit_r;
  logic [IDX_BITS-1:0]   hit_idx_r;
  lfu_cand_t             cand_r   [TREE_N];
  lfu_cand_t             cand_nxt [TREE_N];
  logic [KEY_BITS-1:0]   slot_key_r  [ENTRIES];
  logic [DATA_BITS-1:0]  slot_data_r [ENTRIES];
  logic [COUNT_BITS-1:0] slot_uses_r [ENTRIES];
  logic [FILL_BITS-1:0]  filled_r;
  lfu_out_t              out_r, out_nxt;
  logic                  out_strobe_r;

  logic [ENTRIES-1:0]    match;
  logic                  match_any;
  logic [IDX_BITS-1:0]   match_idx;
  logic                  full;
  logic                  is_put;
  logic [IDX_BITS-1:0]   upd_idx;
  logic [COUNT_BITS-1:0] cur_uses;
  logic [COUNT_BITS-1:0] new_uses;
  logic                  wr_key, wr_data, wr_uses, fill_inc;

  assign full   = (filled_r == FILL_BITS'(ENTRIES));
  assign is_put = (req_r.action == ACT_PUT);

  // parallel compare against the filled slots, lowest index wins
  always_comb begin
    match     = '0;
    match_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = (FILL_BITS'(i) < filled_r) && (slot_key_r[i] == req_r.key);
    end
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) match_idx = IDX_BITS'(i);
    end
  end

  assign match_any       = |match;
  assign stat.evict_need = is_put && !match_any && full;

  // min-count tree: load leaves on lookup, halve once per reduce cycle
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      cand_nxt[i] = cand_r[i];
    end
    if (cmd.lookup) begin
      for (int i = 0; i < TREE_N; i++) begin
        cand_nxt[i] = '0;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        cand_nxt[i].ok   = 1'b1;
        cand_nxt[i].uses = slot_uses_r[i];
        cand_nxt[i].idx  = IDX_BITS'(i);
      end
    end else if (cmd.reduce) begin
      for (int i = 0; i < TREE_N / 2; i++) begin
        cand_nxt[i] = pick(cand_r[2*i], cand_r[2*i+1]);
      end
      for (int i = TREE_N / 2; i < TREE_N; i++) begin
        cand_nxt[i] = '0;
      end
    end
  end

  // write-back selection
  always_comb begin
    if (hit_r) begin
      upd_idx = hit_idx_r;
    end else if (full) begin
      upd_idx = cand_r[0].idx;
    end else begin
      upd_idx = filled_r[IDX_BITS-1:0];
    end
    cur_uses = slot_uses_r[hit_idx_r];
    if (!hit_r) begin
      new_uses = COUNT_BITS'(1);
    end else if (cur_uses == {COUNT_BITS{1'b1}}) begin
      new_uses = cur_uses;
    end else begin
      new_uses = cur_uses + 1'b1;
    end
    wr_key   = cmd.update && is_put && !hit_r;
    wr_data  = cmd.update && is_put;
    wr_uses  = cmd.update && (hit_r || is_put);
    fill_inc = wr_key && !full;

    out_nxt.hit      = hit_r;
    out_nxt.data_out = (!is_put && hit_r) ? WORD_BITS'(slot_data_r[hit_idx_r]) : '0;
    out_nxt.slot     = (!is_put && !hit_r) ? '0 : SLOT_BITS'(upd_idx);
    out_nxt.evicted  = is_put && !hit_r && full;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.update;
      if (fill_inc) filled_r <= filled_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_word;
    if (cmd.lookup) begin
      hit_r     <= match_any;
      hit_idx_r <= match_idx;
    end
    for (int i = 0; i < TREE_N; i++) begin
      cand_r[i] <= cand_nxt[i];
    end
    if (wr_key)  slot_key_r[upd_idx]  <= req_r.key;
    if (wr_data) slot_data_r[upd_idx] <= DATA_BITS'(req_r.data_in);
    if (wr_uses) slot_uses_r[upd_idx] <= new_uses;
    if (cmd.update) out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_r;

  a_evict_not_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.evicted |-> !out_r.hit)
    else $error("eviction reported together with a hit");

  a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.evicted |-> full)
    else $error("eviction while free slots remain");

  a_fill_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(filled_r) |-> $past(cmd.update) && filled_r == $past(filled_r) + 1'b1)
    else $error("fill count moved outside an append");

  a_miss_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_r.hit |-> out_r.data_out == '0)
    else $error("data returned on a miss");

endmodule

// File: rtl/core/lfu_cache_replacement_top.sv
// Top level of the least-frequently-used cache.
// Depends on lfu_pkg, lfu_ctrl and lfu_dp.

// Fully associative LFU cache with ENTRIES (16) slots of key, data word and
// saturating use count. Drive a word on in_word and raise start; it is taken
// at the clock edge where start is high and busy is low. Exactly one result
// word follows on out_word, marked by out_strobe for a single cycle; the
// receiver must take it then, there is no back-pressure. Gets, put hits and
// puts that append to a free slot pass through key compare, then write-back,
// and busy is high from accept through both of those steps.
// A put that misses on a full cache must find the least-used slot, which
// runs through a registered minimum tree one level per cycle between key
// compare and write-back. A new word can be accepted in the same cycle its
// predecessor's result is strobed.
// Ties on the smallest count evict the lowest slot; slot reports the low
// 4 bits of the slot index, and a get miss returns all zeros.
module lfu_cache_replacement_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lfu_pkg::lfu_in_t  in_word,
  output logic             out_strobe,
  output lfu_pkg::lfu_out_t out_word
);
  import lfu_pkg::*;

  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  // sequencer: owns busy and the tree level count
  lfu_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // storage, compare, min tree and registered result word
  lfu_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule
